FILE: sv/wbit_pkg.sv
// Package for the work/break interval timer: mode and beep codes, key codes,
// preset lengths, the result record between core and formatter, and helpers.
// No dependencies.
package wbit_pkg;

    // Width of a remaining-time value in seconds (saturates at 120:59)
    localparam int unsigned LEFT_W     = 13;
    localparam int unsigned SECS_W     = 12;
    localparam logic [LEFT_W-1:0] REMAIN_MAX = 13'd7259;
    localparam logic [SECS_W-1:0] SECS_PER_MIN = 12'd60;

    // Key codes carried by each request
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_PRESET = 2'd2;

    // Preset lengths in minutes
    localparam logic [5:0] WORK_STD   = 6'd25;
    localparam logic [3:0] BREAK_STD  = 4'd5;
    localparam logic [5:0] WORK_LONG  = 6'd50;
    localparam logic [3:0] BREAK_LONG = 4'd10;
    localparam logic [5:0] WORK_SHORT = 6'd15;
    localparam logic [3:0] BREAK_SHORT = 4'd3;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORK   = 2'd1,
        MODE_BREAK  = 2'd2,
        MODE_PAUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        BEEP_NONE   = 2'd0,
        BEEP_PRESET = 2'd1,
        BEEP_RESET  = 2'd2,
        BEEP_EXPIRY = 2'd3
    } beep_t;

    // Result of one request before the minutes/seconds split
    typedef struct packed {
        mode_t             mode;
        logic [LEFT_W-1:0] left;
        logic [5:0]        work_min;
        logic [3:0]        break_min;
        beep_t             beep;
        logic              changed;
    } wbit_result_t;

    // Time left from a signed distance: zero when expired, else saturated
    function automatic logic [LEFT_W-1:0] sat_left(input logic [31:0] span);
        logic [LEFT_W-1:0] res;
        if (span == 32'd0 || span[31])
            res = '0;
        else if (span > {{(32-LEFT_W){1'b0}}, REMAIN_MAX})
            res = REMAIN_MAX;
        else
            res = span[LEFT_W-1:0];
        return res;
    endfunction

    // Minutes to seconds; a 6-bit count times sixty fits in 12 bits
    function automatic logic [SECS_W-1:0] min_to_secs(input logic [5:0] mins);
        logic [SECS_W-1:0] prod;
        prod = {{(SECS_W-6){1'b0}}, mins} * SECS_PER_MIN;
        return prod;
    endfunction

endpackage

FILE: sv/wbit_in_if.sv
// Request channel of the interval timer: key code and seconds timestamp.
// Valid/ready handshake. No dependencies.
interface wbit_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] now_seconds;

    modport source (output valid, kind, now_seconds, input ready);
    modport sink   (input valid, kind, now_seconds, output ready);
endinterface

FILE: sv/wbit_out_if.sv
// Result channel of the interval timer: mode, time left, settings and beep.
// Valid/ready handshake. No dependencies.
interface wbit_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] minutes_left;
    logic [5:0] seconds_part;
    logic [5:0] work_minutes;
    logic [3:0] break_minutes;
    logic [1:0] beep;
    logic       settings_changed;

    modport source (output valid, mode, minutes_left, seconds_part, work_minutes,
                    break_minutes, beep, settings_changed, input ready);
    modport sink   (input valid, mode, minutes_left, seconds_part, work_minutes,
                    break_minutes, beep, settings_changed, output ready);
endinterface

FILE: sv/wbit_core.sv
// Timer state and its combinational next-state update: key handling, expiry, time left.
// Depends on wbit_pkg.
module wbit_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [1:0]            kind,
    input  logic [31:0]           now_seconds,
    output wbit_pkg::wbit_result_t result
);
    import wbit_pkg::*;

    mode_t             mode_reg,   mode_next;
    logic [31:0]       end_reg,    end_next;
    logic [LEFT_W-1:0] pr_reg,     pr_next;
    logic              pwb_reg,    pwb_next;
    logic [5:0]        work_reg,   work_next;
    logic [3:0]        brk_reg,    brk_next;

    logic [31:0]       dist_now;
    logic [31:0]       dist_key;
    logic [LEFT_W-1:0] start_secs;
    logic              use_start;
    mode_t             mode_key;
    logic              running;
    logic              expired;
    logic [SECS_W-1:0] brk_secs;
    logic [LEFT_W-1:0] left;
    beep_t             beep;
    logic              changed;

    // Distance to the stored end time, read as signed
    assign dist_now = end_reg - now_seconds;

    // Apply the key, then check expiry, then form the time left
    always_comb
    begin
        mode_key   = mode_reg;
        end_next   = end_reg;
        pr_next    = pr_reg;
        pwb_next   = pwb_reg;
        work_next  = work_reg;
        brk_next   = brk_reg;
        beep       = BEEP_NONE;
        changed    = 1'b0;
        use_start  = 1'b0;
        start_secs = '0;

        case (kind)
            KIND_START:
            begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        mode_key   = MODE_WORK;
                        use_start  = 1'b1;
                        start_secs = {{(LEFT_W-SECS_W){1'b0}}, min_to_secs(work_reg)};
                    end
                    MODE_WORK, MODE_BREAK:
                    begin
                        pr_next  = sat_left(dist_now);
                        pwb_next = (mode_reg == MODE_BREAK);
                        mode_key = MODE_PAUSED;
                    end
                    default:
                    begin
                        // resume the paused period
                        use_start  = 1'b1;
                        start_secs = pr_reg;
                        mode_key   = pwb_reg ? MODE_BREAK : MODE_WORK;
                    end
                endcase
            end
            KIND_PRESET:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    if (work_reg == WORK_STD)
                    begin
                        work_next = WORK_LONG;
                        brk_next  = BREAK_LONG;
                    end
                    else if (work_reg == WORK_LONG)
                    begin
                        work_next = WORK_SHORT;
                        brk_next  = BREAK_SHORT;
                    end
                    else
                    begin
                        work_next = WORK_STD;
                        brk_next  = BREAK_STD;
                    end
                    changed = 1'b1;
                    beep    = BEEP_PRESET;
                end
                else
                begin
                    mode_key = MODE_IDLE;
                    end_next = '0;
                    pr_next  = '0;
                    beep     = BEEP_RESET;
                end
            end
            default:
            begin
                // tick, or the unused key code
            end
        endcase

        // a freshly started period ends start_secs from now
        if (use_start)
            end_next = now_seconds + {{(32-LEFT_W){1'b0}}, start_secs};
        dist_key = use_start ? {{(32-LEFT_W){1'b0}}, start_secs} : dist_now;

        running  = (mode_key == MODE_WORK) || (mode_key == MODE_BREAK);
        expired  = (dist_key == 32'd0) || dist_key[31];
        brk_secs = min_to_secs({2'b00, brk_next});
        mode_next = mode_key;
        left      = '0;

        if (running && expired)
        begin
            beep = BEEP_EXPIRY;
            if (mode_key == MODE_WORK)
            begin
                mode_next = MODE_BREAK;
                end_next  = now_seconds + {{(32-SECS_W){1'b0}}, brk_secs};
                left      = sat_left({{(32-SECS_W){1'b0}}, brk_secs});
            end
            else
            begin
                mode_next = MODE_IDLE;
                end_next  = '0;
            end
        end
        else if (running)
            left = sat_left(dist_key);
        else if (mode_key == MODE_PAUSED)
            left = (pr_next > REMAIN_MAX) ? REMAIN_MAX : pr_next;
    end

    // Drive the result record
    always_comb
    begin
        result.mode      = mode_next;
        result.left      = left;
        result.work_min  = work_next;
        result.break_min = brk_next;
        result.beep      = beep;
        result.changed   = changed;
    end

    // Hold the timer state; advance once per request taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            end_reg  <= '0;
            pr_reg   <= '0;
            pwb_reg  <= 1'b0;
            work_reg <= WORK_STD;
            brk_reg  <= BREAK_STD;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            end_reg  <= end_next;
            pr_reg   <= pr_next;
            pwb_reg  <= pwb_next;
            work_reg <= work_next;
            brk_reg  <= brk_next;
        end
    end

endmodule

FILE: sv/wbit_fmt.sv
// Splits a remaining time in seconds into minutes and seconds.
// Depends on wbit_pkg.
module wbit_fmt (
    input  logic [wbit_pkg::LEFT_W-1:0] left,
    output logic [6:0]                  minutes,
    output logic [5:0]                  seconds
);
    import wbit_pkg::*;

    // 8739 / 2^19 gives the exact quotient by sixty over 0..7259
    localparam logic [13:0] RECIP_60 = 14'd8739;
    localparam int unsigned RECIP_SH = 19;

    logic [LEFT_W+13:0] prod;
    logic [6:0]         quot;
    logic [LEFT_W-1:0]  quot_x60;
    logic [LEFT_W-1:0]  rem;

    // Quotient by reciprocal, remainder by shift-and-subtract
    assign prod     = {14'd0, left} * {{LEFT_W{1'b0}}, RECIP_60};
    assign quot     = prod[RECIP_SH+6:RECIP_SH];
    assign quot_x60 = ({{(LEFT_W-7){1'b0}}, quot} << 6) - ({{(LEFT_W-7){1'b0}}, quot} << 2);
    assign rem      = left - quot_x60;

    assign minutes = quot;
    assign seconds = rem[5:0];

endmodule

FILE: sv/work_break_interval_timer.sv
// Work/break interval timer. Each request on item carries a key code and the
// current seconds count and gives exactly one result on result. A request is
// taken into an input register, the timer state and the time left are updated
// from it into a second register, and the minutes/seconds split fills the output
// register from that one. One request is accepted every clock cycle while the
// result is not stalled; the state update is a single 32-bit subtract and add
// per cycle, so the rate is set by nothing but the handshakes. While the result
// is stalled, up to three requests are held.
module work_break_interval_timer (
    input  logic              clk,
    input  logic              rst_n,
    wbit_in_if.sink           item,
    wbit_out_if.source        result
);
    import wbit_pkg::*;

    logic              s1_valid_reg;
    logic [1:0]        s1_kind_reg;
    logic [31:0]       s1_now_reg;
    logic              s2_valid_reg;
    wbit_result_t      s2_res_reg;
    logic              out_valid_reg;
    logic [1:0]        out_mode_reg;
    logic [6:0]        out_min_reg;
    logic [5:0]        out_sec_reg;
    logic [5:0]        out_work_reg;
    logic [3:0]        out_brk_reg;
    logic [1:0]        out_beep_reg;
    logic              out_changed_reg;

    logic              out_free;
    logic              s2_free;
    logic              s1_free;
    logic              core_step;
    wbit_result_t      core_res;
    logic [6:0]        fmt_min;
    logic [5:0]        fmt_sec;

    // Stage enables: a stage loads when empty or when it empties this cycle
    assign out_free  = !out_valid_reg || result.ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign core_step = s1_valid_reg && s2_free;
    assign item.ready = s1_free;

    wbit_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (core_step),
        .kind        (s1_kind_reg),
        .now_seconds (s1_now_reg),
        .result      (core_res)
    );

    wbit_fmt u_fmt (
        .left    (s2_res_reg.left),
        .minutes (fmt_min),
        .seconds (fmt_sec)
    );

    // Valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= item.valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_free && item.valid)
        begin
            s1_kind_reg <= item.kind;
            s1_now_reg  <= item.now_seconds;
        end
        if (core_step)
            s2_res_reg <= core_res;
        if (out_free && s2_valid_reg)
        begin
            out_mode_reg    <= s2_res_reg.mode;
            out_min_reg     <= fmt_min;
            out_sec_reg     <= fmt_sec;
            out_work_reg    <= s2_res_reg.work_min;
            out_brk_reg     <= s2_res_reg.break_min;
            out_beep_reg    <= s2_res_reg.beep;
            out_changed_reg <= s2_res_reg.changed;
        end
    end

    // Drive the result channel
    assign result.valid            = out_valid_reg;
    assign result.mode             = out_mode_reg;
    assign result.minutes_left     = out_min_reg;
    assign result.seconds_part     = out_sec_reg;
    assign result.work_minutes     = out_work_reg;
    assign result.break_minutes    = out_brk_reg;
    assign result.beep             = out_beep_reg;
    assign result.settings_changed = out_changed_reg;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the work/break interval timer: random and directed key/tick
// requests, a built-in timer predictor and a field-by-field result check.
// Depends on wbit_pkg, wbit_in_if, wbit_out_if and work_break_interval_timer.
module tb_top;
    import wbit_pkg::*;

    // Spare key code, which the timer treats as a plain tick
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int unsigned RANDOM_REQS = 600;
    localparam int unsigned LONG_HOLD = 80;
    localparam int unsigned MAX_PRINTS = 60;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now;
    } key_req_t;

    typedef struct {
        mode_t      mode;
        logic [6:0] mins;
        logic [5:0] secs;
        logic [5:0] work_min;
        logic [3:0] brk_min;
        beep_t      beep;
        logic       changed;
    } timer_view_t;

    logic clk;
    logic rst_n;

    wbit_in_if  item_ch ();
    wbit_out_if result_ch ();

    work_break_interval_timer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Predicted timer state, at its reset values
    mode_t       tmr_mode   = MODE_IDLE;
    logic [31:0] end_at     = 32'd0;
    logic [12:0] held_left  = 13'd0;
    logic        held_break = 1'b0;
    logic [5:0]  work_len   = WORK_STD;
    logic [3:0]  brk_len    = BREAK_STD;

    key_req_t    pending_reqs[$];
    timer_view_t expected_views[$];

    int unsigned total_reqs   = 0;
    int unsigned req_offered  = 0;
    int unsigned req_taken    = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned send_gap     = 0;
    int unsigned ready_gap    = 0;
    int unsigned next_hold_at = 150;
    int          tx_calm      = 0;
    int          rx_calm      = 0;

    // Signed distance to the end time; expired when zero or negative
    function automatic logic period_over(input logic [31:0] now);
        logic [31:0] span;
        span = end_at - now;
        return (span == 32'd0) || span[31];
    endfunction

    // Seconds left in a running period, clamped to 120:59
    function automatic logic [12:0] secs_remaining(input logic [31:0] now);
        logic [31:0] span;
        span = end_at - now;
        if (span == 32'd0 || span[31])
            return 13'd0;
        if (span > 32'(REMAIN_MAX))
            return REMAIN_MAX;
        return span[12:0];
    endfunction

    // Apply one request to the predicted state and form the display it gives
    function automatic timer_view_t step_timer(input logic [1:0] key,
                                               input logic [31:0] now);
        timer_view_t v;
        logic [12:0] left;
        v.beep    = BEEP_NONE;
        v.changed = 1'b0;
        left      = 13'd0;

        case (key)
            KIND_START:
            begin
                if (tmr_mode == MODE_IDLE)
                begin
                    tmr_mode = MODE_WORK;
                    end_at   = now + 32'(work_len) * 32'(SECS_PER_MIN);
                end
                else if (tmr_mode == MODE_WORK || tmr_mode == MODE_BREAK)
                begin
                    held_left  = secs_remaining(now);
                    held_break = (tmr_mode == MODE_BREAK);
                    tmr_mode   = MODE_PAUSED;
                end
                else
                begin
                    end_at   = now + 32'(held_left);
                    tmr_mode = held_break ? MODE_BREAK : MODE_WORK;
                end
            end
            KIND_PRESET:
            begin
                if (tmr_mode == MODE_IDLE)
                begin
                    // cycle 25/5 -> 50/10 -> 15/3 -> 25/5
                    if (work_len == WORK_STD)
                    begin
                        work_len = WORK_LONG;
                        brk_len  = BREAK_LONG;
                    end
                    else if (work_len == WORK_LONG)
                    begin
                        work_len = WORK_SHORT;
                        brk_len  = BREAK_SHORT;
                    end
                    else
                    begin
                        work_len = WORK_STD;
                        brk_len  = BREAK_STD;
                    end
                    v.changed = 1'b1;
                    v.beep    = BEEP_PRESET;
                end
                else
                begin
                    tmr_mode  = MODE_IDLE;
                    end_at    = 32'd0;
                    held_left = 13'd0;
                    v.beep    = BEEP_RESET;
                end
            end
            default:
            begin
            end
        endcase

        // Expiry is checked after the key, against the same timestamp
        if ((tmr_mode == MODE_WORK || tmr_mode == MODE_BREAK) && period_over(now))
        begin
            v.beep = BEEP_EXPIRY;
            if (tmr_mode == MODE_WORK)
            begin
                tmr_mode = MODE_BREAK;
                end_at   = now + 32'(brk_len) * 32'(SECS_PER_MIN);
            end
            else
            begin
                tmr_mode = MODE_IDLE;
                end_at   = 32'd0;
            end
        end

        if (tmr_mode == MODE_WORK || tmr_mode == MODE_BREAK)
            left = secs_remaining(now);
        else if (tmr_mode == MODE_PAUSED)
            left = (held_left > REMAIN_MAX) ? REMAIN_MAX : held_left;

        v.mode     = tmr_mode;
        v.mins     = 7'(left / 13'd60);
        v.secs     = 6'(left % 13'd60);
        v.work_min = work_len;
        v.brk_min  = brk_len;
        return v;
    endfunction

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int unsigned pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic add_req(input logic [1:0] kind, input logic [31:0] now);
        key_req_t r;
        r.kind = kind;
        r.now  = now;
        pending_reqs.push_back(r);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive every input to a known value from the start
    initial
    begin
        item_ch.valid       = 1'b0;
        item_ch.kind        = KIND_TICK;
        item_ch.now_seconds = 32'd0;
        result_ch.ready     = 1'b0;
    end

    // Request driver: hold each request until taken, then idle a while
    always @(negedge clk)
    begin
        if (!rst_n)
            item_ch.valid = 1'b0;
        else
        begin
            if (item_ch.valid && req_taken == req_offered)
                item_ch.valid = 1'b0;
            if (!item_ch.valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() > 0)
                begin
                    item_ch.kind        = pending_reqs[0].kind;
                    item_ch.now_seconds = pending_reqs[0].now;
                    void'(pending_reqs.pop_front());
                    item_ch.valid = 1'b1;
                    req_offered++;
                    send_gap = pick_idle(tx_calm);
                end
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs that back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready = 1'b0;
        else if (ready_gap > 0)
        begin
            result_ch.ready = 1'b0;
            ready_gap--;
        end
        else if (results_seen >= next_hold_at)
        begin
            result_ch.ready = 1'b0;
            ready_gap       = LONG_HOLD - 1;
            next_hold_at    = next_hold_at + 300;
        end
        else
        begin
            result_ch.ready = 1'b1;
            ready_gap       = pick_idle(rx_calm);
        end
    end

    // Monitor: predict on each taken request, check each taken result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_views.size() == 0)
                    report_mismatch("result with none pending, mode", result_ch.mode, 0);
                else
                begin
                    if (result_ch.mode != expected_views[0].mode)
                        report_mismatch("mode", result_ch.mode, expected_views[0].mode);
                    if (result_ch.minutes_left != expected_views[0].mins)
                        report_mismatch("minutes_left", result_ch.minutes_left,
                                        expected_views[0].mins);
                    if (result_ch.seconds_part != expected_views[0].secs)
                        report_mismatch("seconds_part", result_ch.seconds_part,
                                        expected_views[0].secs);
                    if (result_ch.work_minutes != expected_views[0].work_min)
                        report_mismatch("work_minutes", result_ch.work_minutes,
                                        expected_views[0].work_min);
                    if (result_ch.break_minutes != expected_views[0].brk_min)
                        report_mismatch("break_minutes", result_ch.break_minutes,
                                        expected_views[0].brk_min);
                    if (result_ch.beep != expected_views[0].beep)
                        report_mismatch("beep", result_ch.beep, expected_views[0].beep);
                    if (result_ch.settings_changed != expected_views[0].changed)
                        report_mismatch("settings_changed", result_ch.settings_changed,
                                        expected_views[0].changed);
                    void'(expected_views.pop_front());
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                req_taken++;
                expected_views.push_back(step_timer(item_ch.kind, item_ch.now_seconds));
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [31:0] clock_now;
        logic [1:0]  key;
        int          pick;

        rst_n = 1'b0;

        // Presets cycle through all three settings while idle
        add_req(KIND_TICK, 32'd1000);
        add_req(KIND_PRESET, 32'd1000);
        add_req(KIND_PRESET, 32'd1000);
        add_req(KIND_PRESET, 32'd1000);
        add_req(KIND_SPARE, 32'd1001);
        // Work period whose end time wraps past the top of the counter
        add_req(KIND_START, 32'hFFFF_FF00);
        add_req(KIND_TICK, 32'hFFFF_FFFF);
        add_req(KIND_TICK, 32'h0000_0010);
        add_req(KIND_START, 32'h0000_0020);
        add_req(KIND_TICK, 32'h0000_5000);
        add_req(KIND_START, 32'h0000_5000);
        // Work expires into a break, then the break expires to idle
        add_req(KIND_TICK, 32'h0000_6000);
        add_req(KIND_TICK, 32'h0000_9000);
        // Clock steps back: time left saturates, also when paused
        add_req(KIND_START, 32'd20000);
        add_req(KIND_TICK, 32'd0);
        add_req(KIND_START, 32'd0);
        add_req(KIND_PRESET, 32'd5);
        // Pause after expiry, then resume with nothing left
        add_req(KIND_START, 32'd100);
        add_req(KIND_START, 32'd5100);
        add_req(KIND_START, 32'd6000);
        // Pause and resume a break, then reset from break and from work
        add_req(KIND_START, 32'd6100);
        add_req(KIND_START, 32'd6150);
        add_req(KIND_PRESET, 32'd6200);
        add_req(KIND_START, 32'd7000);
        add_req(KIND_PRESET, 32'd7001);
        // Start at the top of the counter, then jump half the range ahead
        add_req(KIND_START, 32'hFFFF_FFFF);
        add_req(KIND_TICK, 32'h7FFF_FFFF);
        add_req(KIND_PRESET, 32'h8000_0000);

        // Mostly forward-moving time with occasional keys; some jumps anywhere
        clock_now = 32'h8000_0000;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                clock_now = 32'hFFFF_FFFF - $urandom_range(0, 4000);
            else if (pick < 6)
                clock_now = $urandom;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    clock_now = clock_now + $urandom_range(0, 5);
                else if (pick < 85)
                    clock_now = clock_now + $urandom_range(30, 400);
                else
                    clock_now = clock_now + $urandom_range(400, 3200);
            end
            pick = $urandom_range(0, 99);
            if (pick < 72)
                key = KIND_TICK;
            else if (pick < 85)
                key = KIND_START;
            else if (pick < 96)
                key = KIND_PRESET;
            else
                key = KIND_SPARE;
            add_req(key, clock_now);
        end
        total_reqs = pending_reqs.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every request taken, every result seen, then let the pipe settle
        wait (req_taken == total_reqs);
        wait (expected_views.size() == 0);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
